/* rtl/core/kal_pkg.sv */
// ----------------------------------------------------------------------------
// kal_pkg
// Shared types and constants for the k-th ancestor core.
// ----------------------------------------------------------------------------
package kal_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_B0_RD,
      ST_B0_WR,
      ST_BJ_RD,
      ST_BJ_RD2,
      ST_BJ_WR,
      ST_Q_RD,
      ST_OUT
   } state_type;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam int ANC_W = 17;
   localparam logic [ANC_W-1:0] NONE_CODE = '1;

endpackage

/* rtl/core/kth_ancestor_binary_lifting_core.sv */
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting_core
// Parent table and binary-lifting jump table held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_ready | mode, node, parent_or_none, k
//  rsp     | out | rsp_valid/rsp_ready | ancestor
//  csr     | in  | csr_write_enable    | csr_write_data (node_count)
//
// a load takes effect at its accepting edge; loads can follow back to back.
// a query steps through the bits of k, a jump read and a climb per bit, and
// stops early for k zero, a node out of range or a jump that leaves the tree;
// a query after a load or a node_count write first rebuilds the jump table,
// level 0 from the parent table and then each further level from the last.
// reset clears control state only; input waits while a result is held.
// ----------------------------------------------------------------------------
module kth_ancestor_binary_lifting_core #(
   parameter int MAX_NODES   = 65536,
   parameter int JUMP_LEVELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_node,
   input  logic signed [16:0] req_parent_or_none,
   input  logic [15:0] req_k,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [16:0] rsp_ancestor,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data
);

   localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int LW = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
   localparam int CW = NW + 1;
   localparam int AW = LW + NW;

   // memories
   logic [16:0] parent_mem [MAX_NODES];
   logic [16:0] jump_mem [2**AW];

   kal_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic          stale_ff;
   logic [15:0]   node_ff;
   logic [15:0]   k_ff;
   logic [NW-1:0] v_ff, v_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [16:0]   cur_ff, cur_in;
   logic [16:0]   mid_ff, mid_in;
   logic [16:0]   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [16:0]   prd_ff, jrd_ff;
   logic [4:0]    bit_ff, bit_in;
   logic          pwe, jwe;
   logic [NW-1:0] paddr, pwaddr;
   logic [AW-1:0] jraddr, jwaddr;
   logic [16:0]   pwdata, jwdata;
   logic          req_fire;
   logic [CW-1:0] csr_clip;
   logic          v_last;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == kal_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ancestor = rsp_ff;
   assign v_last = ({1'b0, v_ff} == count_ff - CW'(1));

   // register write clamps to 1..MAX_NODES
   always_comb begin
      if (csr_write_data == 17'd0)
         csr_clip = CW'(1);
      else if (32'(csr_write_data) > 32'(MAX_NODES))
         csr_clip = CW'(MAX_NODES);
      else
         csr_clip = CW'(csr_write_data);
   end

   // parent memory port
   always_ff @(posedge clock) begin
      if (pwe)
         parent_mem[pwaddr] <= pwdata;
      prd_ff <= parent_mem[paddr];
   end

   // jump memory port
   always_ff @(posedge clock) begin
      if (jwe)
         jump_mem[jwaddr] <= jwdata;
      jrd_ff <= jump_mem[jraddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kal_pkg::ST_IDLE;
         count_ff     <= CW'(MAX_NODES);
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            count_ff <= csr_clip;
            stale_ff <= 1'b1;
         end else if (req_fire && req_mode == kal_pkg::MODE_LOAD)
            stale_ff <= 1'b1;
         else if (state_ff == kal_pkg::ST_BJ_WR && v_last
                  && lvl_ff == LW'(JUMP_LEVELS - 1))
            stale_ff <= 1'b0;
         else if (state_ff == kal_pkg::ST_B0_WR && v_last && JUMP_LEVELS == 1)
            stale_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         node_ff <= req_node;
         k_ff    <= req_k;
      end
      v_ff   <= v_in;
      lvl_ff <= lvl_in;
      cur_ff <= cur_in;
      mid_ff <= mid_in;
      rsp_ff <= rsp_in;
      bit_ff <= bit_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kal_pkg::ST_IDLE: begin
            if (req_fire && req_mode == kal_pkg::MODE_QUERY)
               state_in = stale_ff ? kal_pkg::ST_B0_RD : kal_pkg::ST_Q_RD;
         end
         kal_pkg::ST_B0_RD: state_in = kal_pkg::ST_B0_WR;
         kal_pkg::ST_B0_WR: begin
            if (!v_last)
               state_in = kal_pkg::ST_B0_RD;
            else if (JUMP_LEVELS == 1)
               state_in = kal_pkg::ST_Q_RD;
            else
               state_in = kal_pkg::ST_BJ_RD;
         end
         kal_pkg::ST_BJ_RD:  state_in = kal_pkg::ST_BJ_RD2;
         kal_pkg::ST_BJ_RD2: state_in = kal_pkg::ST_BJ_WR;
         kal_pkg::ST_BJ_WR: begin
            if (v_last && lvl_ff == LW'(JUMP_LEVELS - 1))
               state_in = kal_pkg::ST_Q_RD;
            else
               state_in = kal_pkg::ST_BJ_RD;
         end
         kal_pkg::ST_Q_RD: state_in = kal_pkg::ST_OUT;
         kal_pkg::ST_OUT: begin
            if (bit_ff == 5'd16 || cur_ff == kal_pkg::NONE_CODE)
               state_in = kal_pkg::ST_IDLE;
            else
               state_in = kal_pkg::ST_Q_RD;
         end
         default: state_in = kal_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      v_in = v_ff;
      lvl_in = lvl_ff;
      cur_in = cur_ff;
      mid_in = mid_ff;
      rsp_in = rsp_ff;
      bit_in = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pwe = 1'b0;
      pwaddr = req_node[NW-1:0];
      pwdata = req_parent_or_none;
      paddr = v_ff;
      jwe = 1'b0;
      jwaddr = {lvl_ff, v_ff};
      jwdata = kal_pkg::NONE_CODE;
      jraddr = {lvl_ff, v_ff};
      case (state_ff)
         kal_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == kal_pkg::MODE_LOAD)
                  pwe = (32'(req_node) < 32'(MAX_NODES));
               v_in = '0;
               lvl_in = '0;
               cur_in = {1'b0, req_node};
               bit_in = 5'd0;
            end
         end
         kal_pkg::ST_B0_WR: begin
            // level 0: parent, root and out-of-range parents map to none
            jwe = 1'b1;
            jwaddr = {LW'(0), v_ff};
            if (v_ff == '0 || prd_ff[16] || 32'(prd_ff) >= 32'(count_ff))
               jwdata = kal_pkg::NONE_CODE;
            else
               jwdata = prd_ff;
            v_in = v_last ? '0 : v_ff + NW'(1);
            lvl_in = LW'(1);
         end
         kal_pkg::ST_BJ_RD: begin
            jraddr = {lvl_ff - LW'(1), v_ff};
         end
         kal_pkg::ST_BJ_RD2: begin
            // second hop through the level j-1 ancestor
            mid_in = jrd_ff;
            jraddr = {lvl_ff - LW'(1), jrd_ff[NW-1:0]};
         end
         kal_pkg::ST_BJ_WR: begin
            jwe = 1'b1;
            jwdata = mid_ff[16] ? kal_pkg::NONE_CODE : jrd_ff;
            if (v_last) begin
               v_in = '0;
               lvl_in = lvl_ff + LW'(1);
            end else
               v_in = v_ff + NW'(1);
         end
         kal_pkg::ST_Q_RD: begin
            // jump read for the current bit of k
            jraddr = {bit_ff[LW-1:0], cur_ff[NW-1:0]};
         end
         kal_pkg::ST_OUT: begin
            if (bit_ff == 5'd0 && k_ff == 16'd0)
               cur_in = {1'b0, node_ff};
            else if (bit_ff == 5'd0 && 32'(node_ff) >= 32'(count_ff))
               cur_in = kal_pkg::NONE_CODE;
            else if (k_ff[bit_ff[3:0]]) begin
               if (32'(bit_ff) >= 32'(JUMP_LEVELS))
                  cur_in = kal_pkg::NONE_CODE;
               else
                  cur_in = jrd_ff;
            end
            if (k_ff == 16'd0 || (bit_ff == 5'd0 && 32'(node_ff) >= 32'(count_ff)))
               bit_in = 5'd16;
            else
               bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd16 || cur_ff == kal_pkg::NONE_CODE) begin
               rsp_in = cur_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   // no new request while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while result pending");
   // a result appears only from the climb step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == kal_pkg::ST_OUT))
      else $error("result without climb");
   // query never starts on a stale table
   a_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kal_pkg::ST_Q_RD && !csr_write_enable) |-> !stale_ff)
      else $error("climb on stale table");
`endif

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// k-th ancestor core testbench
// Loads random trees into the core, asks random ancestor queries under random
// back-pressure and compares each answer with a binary-lifting predictor.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXN     = 512;
   localparam int LEVELS   = 16;
   localparam int WD_LIMIT = 400000;

   typedef struct {
      logic                             mode;
      logic [15:0]                      node;
      logic signed [kal_pkg::ANC_W-1:0] parent;
      logic [15:0]                      k;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_mode = kal_pkg::MODE_LOAD;
   logic [15:0] req_node = '0, req_k = '0;
   logic signed [16:0] req_parent_or_none = '0;
   logic req_ready, rsp_valid, rsp_ready = 1'b0;
   logic signed [16:0] rsp_ancestor;
   logic csr_write_enable = 1'b0;
   logic [16:0] csr_write_data = '0;

   kth_ancestor_binary_lifting_core #(.MAX_NODES(MAXN), .JUMP_LEVELS(LEVELS)) dut (.*);

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   request_type                      pending_reqs[$];
   logic signed [kal_pkg::ANC_W-1:0] expected_anc[$];
   int  mismatches = 0;
   bit  req_took = 0;
   bit  quiet = 0;
   int  answers_seen = 0;

   // predictor state
   logic signed [kal_pkg::ANC_W-1:0] parent_mem[MAXN];
   bit                               loaded[MAXN];
   int                               jumps[LEVELS][MAXN];
   bit                               stale = 1;
   int                               active_nodes = 65536 > MAXN ? MAXN : 65536;

   function automatic void add_request(request_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic void rebuild_jumps();
      int p;
      for (int v = 0; v < active_nodes; v++) begin
         p = parent_mem[v];
         if (v == 0 || p < 0 || p >= active_nodes) p = -1;
         jumps[0][v] = p;
      end
      for (int j = 1; j < LEVELS; j++)
         for (int v = 0; v < active_nodes; v++)
            jumps[j][v] = (jumps[j-1][v] < 0) ? -1 : jumps[j-1][jumps[j-1][v]];
      stale = 0;
   endfunction

   function automatic logic signed [kal_pkg::ANC_W-1:0] kth_ancestor(logic [15:0] node,
                                                                     logic [15:0] k);
      int cur;
      if (k == 0) return {1'b0, node};
      if (node >= active_nodes) return kal_pkg::NONE_CODE;
      cur = node;
      for (int j = 0; j < 16; j++) begin
         if (k[j]) begin
            if (j >= LEVELS) return kal_pkg::NONE_CODE;
            cur = jumps[j][cur];
            if (cur < 0) return kal_pkg::NONE_CODE;
         end
      end
      return cur[kal_pkg::ANC_W-1:0];
   endfunction

   // monitor: predict on accepted requests, check accepted responses
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 0;
      end else begin
         req_took <= req_valid && req_ready;
         if (csr_write_enable) begin
            active_nodes = csr_write_data < 1 ? 1 : (csr_write_data > MAXN ? MAXN
                           : int'(csr_write_data));
            stale = 1;
         end
         if (req_valid && req_ready) begin
            if (req_mode == kal_pkg::MODE_LOAD) begin
               if (req_node < MAXN) begin
                  parent_mem[req_node] = req_parent_or_none;
                  loaded[req_node] = 1;
               end
               stale = 1;
            end else begin
               if (stale) rebuild_jumps();
               expected_anc.insert(expected_anc.size(), kth_ancestor(req_node, req_k));
            end
         end
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (expected_anc.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %0d",
                        $time, rsp_ancestor);
               mismatches++;
            end else begin
               if (rsp_ancestor !== expected_anc[0]) begin
                  $display("%0t: ancestor mismatch, expected %0d actual %0d",
                           $time, expected_anc[0], rsp_ancestor);
                  mismatches++;
               end
               void'(expected_anc.pop_front());
            end
         end
         // watchdog on cycles without any handshake
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // request driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_took)) begin
         if (req_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
            req_gap = $urandom_range(1, 16);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid          <= 1'b1;
            req_mode           <= pending_reqs[0].mode;
            req_node           <= pending_reqs[0].node;
            req_parent_or_none <= pending_reqs[0].parent;
            req_k              <= pending_reqs[0].k;
            void'(pending_reqs.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response acceptor with random stalls and one long hold-off
   int rsp_gap = 0;
   bit held = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!held && answers_seen >= 100) begin
            held = 1;
            rsp_gap = 400;
         end
         if (rsp_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
            rsp_gap = $urandom_range(1, 16);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic request_type make_load(int node, int parent);
      request_type r;
      r.mode = kal_pkg::MODE_LOAD;
      r.node = node[15:0];
      r.parent = parent[16:0];
      r.k = 16'($urandom());
      return r;
   endfunction

   function automatic request_type make_query(int node, int k);
      request_type r;
      r.mode = kal_pkg::MODE_QUERY;
      r.node = node[15:0];
      r.parent = 17'($urandom());
      r.k = k[15:0];
      return r;
   endfunction

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_anc.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_node_count(int value);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[16:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // tree for every node not yet written below the active count
   task automatic load_tree(int n, bit chain);
      for (int v = 0; v < n; v++)
         if (!loaded[v]) begin
            loaded[v] = 1;
            add_request(make_load(v, v == 0 ? -1 :
               (chain ? v - 1 : $urandom_range(0, v - 1))));
         end
   endtask

   function automatic int random_parent(int n);
      case ($urandom_range(0, 9))
         0: return -1;
         1: return $urandom_range(0, 65535);
         default: return $urandom_range(0, n - 1);
      endcase
   endfunction

   task automatic random_requests(int n, int count, int load_pct);
      int node, k;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < load_pct) begin
            if ($urandom_range(0, 4) == 0) node = $urandom_range(0, 65535);
            else node = $urandom_range(0, n - 1);
            if (node < MAXN) loaded[node] = 1;
            add_request(make_load(node, random_parent(n)));
         end else begin
            node = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, n - 1);
            case ($urandom_range(0, 5))
               0: k = $urandom_range(0, 65535);
               1: k = 0;
               default: k = $urandom_range(0, n + 2);
            endcase
            add_request(make_query(node, k));
         end
      end
   endtask

   // stimulus
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: small tree with special cases
      set_node_count(8);
      load_tree(8, 0);
      add_request(make_load(0, 5));      // root parent ignored
      add_request(make_load(3, 2));
      add_request(make_load(2, 1));
      add_request(make_load(1, 0));
      add_request(make_load(4, 9));      // out of range parent
      add_request(make_load(5, 65535));
      add_request(make_load(6, -1));
      add_request(make_load(65535, 3));  // node beyond the table
      add_request(make_query(3, 3));
      add_request(make_query(3, 4));
      add_request(make_query(0, 0));
      add_request(make_query(0, 1));
      add_request(make_query(65535, 0));
      add_request(make_query(65535, 1));
      add_request(make_query(8, 1));
      add_request(make_query(3, 65535));
      add_request(make_query(4, 1));
      add_request(make_query(5, 1));
      // a parent cycle between two nodes
      add_request(make_load(7, 6));
      add_request(make_load(6, 7));
      add_request(make_query(7, 5));
      add_request(make_query(6, 32768));
      random_requests(8, 150, 10);

      set_node_count(0);
      random_requests(1, 60, 10);

      set_node_count(2);
      load_tree(2, 0);
      random_requests(2, 100, 10);

      set_node_count(65536);
      load_tree(MAXN, 1);
      random_requests(MAXN, 60, 2);

      set_node_count(40);
      random_requests(40, 200, 8);

      set_node_count(131071);
      random_requests(MAXN, 40, 0);

      set_node_count(13);
      random_requests(13, 200, 10);

      set_node_count(25);
      wait_idle();
      quiet = 1;
      random_requests(25, 200, 10);

      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_anc.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
